@@ src/gpio_pkg.sv @@
// Shared types, register codes and helpers for the GPIO port register block.
`default_nettype none

package gpio_pkg;

  localparam int PinCountDefault = 16;
  localparam int PinWidth        = 16;
  localparam int DataWidth       = 32;
  localparam int IndexWidth      = 3;
  localparam int KeyBitPos       = 16;
  localparam logic [31:0] CfgResetValue = 32'h4444_4444;

  typedef enum logic {
    OpRead  = 1'b0,
    OpWrite = 1'b1
  } op_e;

  typedef enum logic [IndexWidth-1:0] {
    RegCfgLow   = 3'd0,
    RegCfgHigh  = 3'd1,
    RegInput    = 3'd2,
    RegOutput   = 3'd3,
    RegSetReset = 3'd4,
    RegReset    = 3'd5,
    RegLock     = 3'd6
  } reg_idx_e;

  // One access to the lock register, as seen by the key sequencer.
  typedef struct packed {
    logic                wr;
    logic                rd;
    logic                key;
    logic [PinWidth-1:0] mask;
  } lock_req_t;

  // Widens one enable bit per pin into a 4-bit field per pin.
  function automatic logic [31:0] expand_nibbles(input logic [7:0] pins);
    logic [31:0] m;
    m = '0;
    for (int p = 0; p < 8; p++) begin
      m[4*p +: 4] = {4{pins[p]}};
    end
    return m;
  endfunction

endpackage

`default_nettype wire

@@ src/gpio_lock.sv @@
// Lock key sequencer: tracks the key writes and holds the frozen pin set.
`default_nettype none

module gpio_lock (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire gpio_pkg::lock_req_t               req_i,
  output logic [gpio_pkg::PinWidth-1:0]          locked_pins_o,
  output logic [gpio_pkg::KeyBitPos:0]           lock_rdata_o,
  output logic                                   lock_active_o
);
  import gpio_pkg::*;

  typedef enum logic [2:0] {
    KeyIdle     = 3'd0,
    KeyOneSeen  = 3'd1,
    KeyZeroSeen = 3'd2,
    KeyLockNew  = 3'd3,
    KeyLocked   = 3'd4
  } key_step_e;

  key_step_e             step_q, step_d;
  logic [PinWidth-1:0]   seen_q, seen_d;
  logic [PinWidth-1:0]   locked_q, locked_d;
  logic                  is_locked;

  assign is_locked = (step_q == KeyLockNew) || (step_q == KeyLocked);

  always_comb begin
    step_d   = step_q;
    seen_d   = seen_q;
    locked_d = locked_q;
    if (req_i.wr && !is_locked) begin
      if (step_q == KeyOneSeen && !req_i.key && req_i.mask == seen_q) begin
        step_d = KeyZeroSeen;
      end else if (step_q == KeyZeroSeen && req_i.key && req_i.mask == seen_q) begin
        step_d   = KeyLockNew;
        locked_d = req_i.mask;
      end else begin
        step_d = req_i.key ? KeyOneSeen : KeyIdle;
        seen_d = req_i.mask;
      end
    end else if (req_i.rd && step_q == KeyLockNew) begin
      // The first read after locking shows the key bit clear.
      step_d = KeyLocked;
    end
  end

  always_comb begin
    case (step_q)
      KeyLockNew: lock_rdata_o = {1'b0, locked_q};
      KeyLocked:  lock_rdata_o = {1'b1, locked_q};
      KeyOneSeen: lock_rdata_o = {1'b1, seen_q};
      default:    lock_rdata_o = {1'b0, seen_q};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= KeyIdle;
      seen_q   <= '0;
      locked_q <= '0;
    end else begin
      step_q   <= step_d;
      seen_q   <= seen_d;
      locked_q <= locked_d;
    end
  end

  assign locked_pins_o = locked_q;
  assign lock_active_o = is_locked;

endmodule

`default_nettype wire

@@ src/gpio_port_register_block.sv @@
// Top level of the GPIO port register block.
//
// One bus access is a transfer on the command channel: start_i high while
// busy_o is low accepts operation_i, register_index_i, write_data_i and
// pin_levels_i. busy_o stays low, so an access can be accepted every cycle.
// The access is held in an input register and then applied to the register
// state; its result is registered and appears on read_data_o,
// pin_drive_o and lock_active_o, marked by done_o for exactly one cycle.
// Throughput is one access per cycle; each access passes the input register,
// the decode logic and the result register in order.
// pin_drive_o and lock_active_o show the state after the latest completed
// access and hold between results. The receiver cannot hold results off;
// each one is valid only in its done_o cycle.
// Reset sets both config registers to 0x44444444, clears the output data,
// the lock state and any pending access. A completed lock sequence freezes
// the config nibbles of the selected pins until the next reset.
`default_nettype none

module gpio_port_register_block #(
  parameter int PIN_COUNT = gpio_pkg::PinCountDefault
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  output logic                                     busy_o,
  input  wire logic                                operation_i,
  input  wire logic [gpio_pkg::IndexWidth-1:0]     register_index_i,
  input  wire logic [gpio_pkg::DataWidth-1:0]      write_data_i,
  input  wire logic [gpio_pkg::PinWidth-1:0]       pin_levels_i,
  output logic                                     done_o,
  output logic [gpio_pkg::DataWidth-1:0]           read_data_o,
  output logic [gpio_pkg::PinWidth-1:0]            pin_drive_o,
  output logic                                     lock_active_o
);
  import gpio_pkg::*;

  localparam logic [PinWidth-1:0] PinMask = PinWidth'((32'd1 << PIN_COUNT) - 32'd1);

  // Input register.
  logic                  valid_q;
  logic                  op_q;
  logic [IndexWidth-1:0] idx_q;
  logic [DataWidth-1:0]  wdata_q;
  logic [PinWidth-1:0]   levels_q;

  // Register state and result register.
  logic [DataWidth-1:0]  cfg_low_q, cfg_low_d;
  logic [DataWidth-1:0]  cfg_high_q, cfg_high_d;
  logic [PinWidth-1:0]   out_q, out_d;
  logic [DataWidth-1:0]  rdata_q, rdata_d;
  logic                  done_q;

  logic                  is_write;
  logic                  is_read;
  lock_req_t             lock_req;
  logic [PinWidth-1:0]   locked_pins;
  logic [KeyBitPos:0]    lock_rdata;
  logic                  lock_active;
  logic [PinWidth-1:0]   pin_writable;
  logic [DataWidth-1:0]  low_mask;
  logic [DataWidth-1:0]  high_mask;

  assign busy_o   = 1'b0;
  assign is_write = valid_q && (op_e'(op_q) == OpWrite);
  assign is_read  = valid_q && (op_e'(op_q) == OpRead);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      op_q     <= operation_i;
      idx_q    <= register_index_i;
      wdata_q  <= write_data_i;
      levels_q <= pin_levels_i;
    end
  end

  assign lock_req.wr   = is_write && (reg_idx_e'(idx_q) == RegLock);
  assign lock_req.rd   = is_read && (reg_idx_e'(idx_q) == RegLock);
  assign lock_req.key  = wdata_q[KeyBitPos];
  assign lock_req.mask = wdata_q[PinWidth-1:0] & PinMask;

  gpio_lock u_lock (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (lock_req),
    .locked_pins_o (locked_pins),
    .lock_rdata_o  (lock_rdata),
    .lock_active_o (lock_active)
  );

  // Only present, unlocked pins take config writes.
  assign pin_writable = PinMask & ~locked_pins;
  assign low_mask     = expand_nibbles(pin_writable[7:0]);
  assign high_mask    = expand_nibbles(pin_writable[15:8]);

  always_comb begin
    cfg_low_d  = cfg_low_q;
    cfg_high_d = cfg_high_q;
    out_d      = out_q;
    if (is_write) begin
      case (reg_idx_e'(idx_q))
        RegCfgLow:   cfg_low_d  = (cfg_low_q & ~low_mask) | (wdata_q & low_mask);
        RegCfgHigh:  cfg_high_d = (cfg_high_q & ~high_mask) | (wdata_q & high_mask);
        RegOutput:   out_d = wdata_q[PinWidth-1:0] & PinMask;
        // Set wins over clear when both halves name the same pin.
        RegSetReset: out_d = ((out_q & ~wdata_q[31:16]) | wdata_q[15:0]) & PinMask;
        RegReset:    out_d = out_q & ~wdata_q[PinWidth-1:0] & PinMask;
        default:     out_d = out_q;
      endcase
    end
  end

  always_comb begin
    rdata_d = '0;
    if (is_read) begin
      case (reg_idx_e'(idx_q))
        RegCfgLow:  rdata_d = cfg_low_q;
        RegCfgHigh: rdata_d = cfg_high_q;
        RegInput:   rdata_d = DataWidth'(levels_q & PinMask);
        RegOutput:  rdata_d = DataWidth'(out_q);
        RegLock:    rdata_d = DataWidth'(lock_rdata);
        default:    rdata_d = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_low_q  <= CfgResetValue;
      cfg_high_q <= CfgResetValue;
      out_q      <= '0;
      done_q     <= 1'b0;
    end else begin
      cfg_low_q  <= cfg_low_d;
      cfg_high_q <= cfg_high_d;
      out_q      <= out_d;
      done_q     <= valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= rdata_d;
  end

  assign done_o        = done_q;
  assign read_data_o   = rdata_q;
  assign pin_drive_o   = out_q;
  assign lock_active_o = lock_active;

endmodule

`default_nettype wire

@@ src/gpio_checker.sv @@
// Port-level checker for the GPIO port register block, bound to the top level.
`default_nettype none

module gpio_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                start_i,
  input wire logic                                busy_o,
  input wire logic                                operation_i,
  input wire logic                                done_o,
  input wire logic [gpio_pkg::DataWidth-1:0]      read_data_o,
  input wire logic                                lock_active_o
);
  import gpio_pkg::*;

  logic accept;
  assign accept = start_i && !busy_o;

  // Every accepted access gives exactly one result, after the input register and the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##1 done_o)
    else $error("accepted access gave no result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> ##1 !done_o)
    else $error("result without an accepted access");

  // A write returns zero read data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (op_e'(operation_i) == OpWrite)) |=> ##1 (read_data_o == '0))
    else $error("write returned nonzero read data");

  // Once locked, the port stays locked until reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    lock_active_o |=> lock_active_o)
    else $error("lock released without reset");

endmodule

bind gpio_port_register_block gpio_checker u_gpio_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .operation_i   (operation_i),
  .done_o        (done_o),
  .read_data_o   (read_data_o),
  .lock_active_o (lock_active_o)
);

`default_nettype wire
